// ===== hdl/bmr_pkg.sv =====
// ----------------------------------------------------------------------------
// bmr_pkg: shared types and constants for the bank mapper with RTC
// Item layouts, command and target codes, address windows and clock limits.
// ----------------------------------------------------------------------------
package bmr_pkg;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_RAM_PRESENT = 1'b0;  // register index, paddr[2]

  // Commands
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  // Targets
  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_ROM  = 2'd1;
  localparam logic [1:0] TGT_RAM  = 2'd2;
  localparam logic [1:0] TGT_RTC  = 2'd3;

  // Control write regions, address[14:13] below 0x8000
  localparam logic [1:0] CTL_RAM_EN   = 2'd0;
  localparam logic [1:0] CTL_ROM_BANK = 2'd1;
  localparam logic [1:0] CTL_BANK_SEL = 2'd2;
  localparam logic [1:0] CTL_LATCH    = 2'd3;

  localparam logic [2:0]  EXT_WINDOW  = 3'b101;   // 0xA000-0xBFFF, address[15:13]
  localparam logic [3:0]  RAM_EN_KEY  = 4'hA;
  localparam logic [7:0]  RTC_SEL_LO  = 8'h08;
  localparam logic [7:0]  RTC_SEL_HI  = 8'h0C;
  localparam logic [7:0]  RAM_SEL_LIM = 8'h04;
  localparam logic [7:0]  BAD_DATA    = 8'hFF;

  // RTC register indexes (bank_select - 0x08)
  localparam logic [2:0] RTC_SEC  = 3'd0;
  localparam logic [2:0] RTC_MIN  = 3'd1;
  localparam logic [2:0] RTC_HOUR = 3'd2;
  localparam logic [2:0] RTC_DL   = 3'd3;
  localparam logic [2:0] RTC_DH   = 3'd4;

  localparam int DH_HALT_BIT  = 6;
  localparam int DH_CARRY_BIT = 7;

  localparam int SECS_PER_MIN  = 60;
  localparam int MINS_PER_HOUR = 60;
  localparam int HOURS_PER_DAY = 24;
  localparam longint SECS_PER_DAY = 86400;

  // Saturation point of the pending count (0xFFFFFFFF seconds) in d/h/m/s
  localparam longint PEND_MAX   = 64'hFFFF_FFFF;
  localparam longint PEND_REM   = PEND_MAX % SECS_PER_DAY;
  localparam logic [15:0] PEND_SAT_DAY  = 16'(PEND_MAX / SECS_PER_DAY);
  localparam logic [4:0]  PEND_SAT_HOUR = 5'(PEND_REM / 3600);
  localparam logic [5:0]  PEND_SAT_MIN  = 6'((PEND_REM % 3600) / 60);
  localparam logic [5:0]  PEND_SAT_SEC  = 6'(PEND_REM % 60);

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] address;
    logic [7:0]  data;
  } req_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [20:0] phys_addr;
    logic        ram_write_strobe;
    logic [7:0]  read_data;
    logic        bad_access;
  } rsp_t;

  // Requests from the mapper to the clock unit
  typedef struct packed {
    logic       tick;     // one-second tick
    logic       latched;  // ticks go to the pending count
    logic       apply;    // unlatch: add the pending count to the clock
    logic       wr_en;    // register write
    logic [2:0] sel;      // register index for read and write
    logic [7:0] wdata;
  } rtc_ctl_t;

endpackage

// ===== hdl/bank_mapper_with_rtc.sv =====
// ----------------------------------------------------------------------------
// bank_mapper_with_rtc: cartridge bank mapper with real-time clock
// Maps bus reads and writes to ROM/RAM addresses or RTC registers.
// ----------------------------------------------------------------------------
// Every item is one bus read, bus write or one-second tick and yields exactly
// one result item. Items enter an input register, are decoded and applied to
// the mapper and clock state, and the result lands in an output register;
// one item per cycle is sustained while the result side does not stall, and
// the input refills as it drains. A held result does not block the
// input side: one more item is taken into the input register while the
// result waits. Writes below 0x8000 program RAM enable, ROM bank (0 reads as
// 1), the RAM bank / RTC select and the latch (write 0 then 1 to toggle).
// While latched, ticks build up a pending count (saturating at 0xFFFFFFFF
// seconds, kept as days/hours/minutes/seconds) that is added to the clock
// on unlatch. ram_present (APB offset 0x0) should only be written while idle.
// ----------------------------------------------------------------------------
module bank_mapper_with_rtc (
  input  logic                        clk,
  input  logic                        rst,
  // request channel
  input  logic                        req_valid,
  output logic                        req_stall,
  input  bmr_pkg::req_t               req,
  // result channel
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output bmr_pkg::rsp_t               rsp,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bmr_pkg::PADDR_W-1:0] paddr,
  input  logic [bmr_pkg::PDATA_W-1:0] pwdata,
  output logic [bmr_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import bmr_pkg::*;

  // Input stage
  logic       req_full;
  req_t       req_q;
  logic       work;       // the held item is processed this cycle
  logic       accept;

  // Mapper state
  logic       ram_present;
  logic [6:0] rom_bank;
  logic [7:0] bank_select;
  logic       ram_enable;
  logic       latch_armed;
  logic       latched;

  logic [6:0] rom_bank_next;
  logic [7:0] bank_select_next;
  logic       ram_enable_next;
  logic       latch_armed_next;
  logic       latched_next;

  rsp_t       rsp_next;
  rtc_ctl_t   ctl;
  logic [7:0] rtc_rd;
  logic       bad;
  logic       in_window;
  logic       sel_ram;
  logic       sel_rtc;
  logic [20:0] ram_addr;

  // --- Handshake: input register feeds the output register ---
  assign work      = req_full && (!rsp_valid || !rsp_stall);
  assign req_stall = req_full && !work;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
    end else if (accept) begin
      req_full <= 1'b1;
    end else if (work) begin
      req_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) req_q <= req;
  end

  // --- Configuration port ---
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RAM_PRESENT) ? PDATA_W'(ram_present) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_present <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_RAM_PRESENT) begin
      ram_present <= pwdata[0];
    end
  end

  // --- Decode ---
  assign in_window = (req_q.address[15:13] == EXT_WINDOW);
  assign sel_ram   = (bank_select < RAM_SEL_LIM);
  assign sel_rtc   = (bank_select >= RTC_SEL_LO) && (bank_select <= RTC_SEL_HI);
  // bank * 8 KiB + offset within the window
  assign ram_addr  = 21'({bank_select[1:0], req_q.address[12:0]});

  always_comb begin
    rsp_next         = '0;
    bad              = 1'b0;
    ctl              = '0;
    ctl.latched      = latched;
    ctl.sel          = bank_select[2:0];   // 0x08..0x0C -> 0..4
    ctl.wdata        = req_q.data;
    rom_bank_next    = rom_bank;
    bank_select_next = bank_select;
    ram_enable_next  = ram_enable;
    latch_armed_next = latch_armed;
    latched_next     = latched;

    case (req_q.cmd)
      CMD_TICK: begin
        ctl.tick = 1'b1;
      end
      CMD_NONE: begin
        bad = 1'b1;
      end
      default: begin
        if (!req_q.address[15]) begin
          if (req_q.cmd == CMD_READ) begin
            // bank 0 fixed at 0x0000, switchable bank at 0x4000
            rsp_next.target = TGT_ROM;
            if (!req_q.address[14]) begin
              rsp_next.phys_addr = 21'(req_q.address[13:0]);
            end else begin
              rsp_next.phys_addr = {rom_bank, req_q.address[13:0]};
            end
          end else begin
            case (req_q.address[14:13])
              CTL_RAM_EN: begin
                if (ram_present) ram_enable_next = (req_q.data[3:0] == RAM_EN_KEY);
              end
              CTL_ROM_BANK: begin
                rom_bank_next = (req_q.data[6:0] == '0) ? 7'd1 : req_q.data[6:0];
              end
              CTL_BANK_SEL: begin
                bank_select_next = req_q.data;
              end
              default: begin
                if (latch_armed && req_q.data == 8'd1) begin
                  latched_next     = !latched;
                  latch_armed_next = 1'b0;
                  ctl.apply        = latched;   // releasing the latch
                end else begin
                  latch_armed_next = (req_q.data == 8'd0);
                end
              end
            endcase
          end
        end else if (in_window) begin
          if (sel_ram) begin
            if (ram_present) begin
              rsp_next.target           = TGT_RAM;
              rsp_next.phys_addr        = ram_addr;
              rsp_next.ram_write_strobe = (req_q.cmd == CMD_WRITE) && ram_enable;
            end else if (req_q.cmd == CMD_READ) begin
              bad = 1'b1;
            end
          end else if (sel_rtc) begin
            if (req_q.cmd == CMD_WRITE) begin
              rsp_next.target = TGT_RTC;
              ctl.wr_en       = 1'b1;
            end else if (ram_present) begin
              rsp_next.target    = TGT_RTC;
              rsp_next.read_data = rtc_rd;
            end else begin
              bad = 1'b1;
            end
          end else begin
            bad = 1'b1;
          end
        end else begin
          bad = 1'b1;
        end
      end
    endcase

    if (bad) begin
      rsp_next            = '0;
      rsp_next.read_data  = BAD_DATA;
      rsp_next.bad_access = 1'b1;
    end

    // clock unit only acts on the item being processed
    if (!work) begin
      ctl.tick  = 1'b0;
      ctl.apply = 1'b0;
      ctl.wr_en = 1'b0;
    end
  end

  // --- Mapper state ---
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank    <= 7'd1;
      bank_select <= '0;
      ram_enable  <= 1'b0;
      latch_armed <= 1'b0;
      latched     <= 1'b0;
    end else if (work) begin
      rom_bank    <= rom_bank_next;
      bank_select <= bank_select_next;
      ram_enable  <= ram_enable_next;
      latch_armed <= latch_armed_next;
      latched     <= latched_next;
    end
  end

  bmr_rtc u_rtc (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .rd_data (rtc_rd)
  );

  // --- Output register ---
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (work) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (work) rsp <= rsp_next;
  end

endmodule

// ===== hdl/bmr_rtc.sv =====
// ----------------------------------------------------------------------------
// bmr_rtc: real-time clock registers and pending-second counter
// Advances sec/min/hour/day with carry and halt, counts ticks while latched.
// ----------------------------------------------------------------------------
module bmr_rtc (
  input  logic              clk,
  input  logic              rst,
  input  bmr_pkg::rtc_ctl_t ctl,
  output logic [7:0]        rd_data
);
  import bmr_pkg::*;

  typedef struct packed {
    logic [7:0] sec;
    logic [7:0] min;
    logic [7:0] hour;
    logic [7:0] dl;
    logic [7:0] dh;
  } clk_t;

  clk_t        clock_regs;
  logic [5:0]  p_sec;
  logic [5:0]  p_min;
  logic [4:0]  p_hour;
  logic [15:0] p_day;

  clk_t        tick_next;
  clk_t        apply_next;
  logic        pend_nz;
  logic        pend_sat;
  logic [5:0]  p_sec_next;
  logic [5:0]  p_min_next;
  logic [4:0]  p_hour_next;
  logic [15:0] p_day_next;

  function automatic logic [2:0] div60(input logic [8:0] x);
    logic [2:0] q;
    q = '0;
    for (int k = 1; k <= 5; k++) begin
      if (x >= 9'(SECS_PER_MIN * k)) q = q + 3'd1;
    end
    return q;
  endfunction

  function automatic logic [3:0] div24(input logic [8:0] x);
    logic [3:0] q;
    q = '0;
    for (int k = 1; k <= 11; k++) begin
      if (x >= 9'(HOURS_PER_DAY * k)) q = q + 4'd1;
    end
    return q;
  endfunction

  // Adds d/h/m/s to the clock; inputs stay below 60/60/24 so each carry is small
  function automatic clk_t advance(input clk_t c, input logic [5:0] ps,
                                   input logic [5:0] pm, input logic [4:0] ph,
                                   input logic [15:0] pd);
    logic [8:0]  s;
    logic [8:0]  m;
    logic [8:0]  h;
    logic [2:0]  q1;
    logic [2:0]  q2;
    logic [3:0]  q3;
    logic [16:0] d;
    clk_t        n;
    s  = 9'(c.sec) + 9'(ps);
    q1 = div60(s);
    m  = 9'(c.min) + 9'(pm) + 9'(q1);
    q2 = div60(m);
    h  = 9'(c.hour) + 9'(ph) + 9'(q2);
    q3 = div24(h);
    d  = 17'({c.dh[0], c.dl}) + 17'(pd) + 17'(q3);
    n.sec  = 8'(s - 9'(q1) * 9'(SECS_PER_MIN));
    n.min  = 8'(m - 9'(q2) * 9'(MINS_PER_HOUR));
    n.hour = 8'(h - 9'(q3) * 9'(HOURS_PER_DAY));
    n.dl   = d[7:0];
    n.dh   = c.dh;
    if (d[16:9] != '0) n.dh[DH_CARRY_BIT] = 1'b1;
    n.dh[0] = d[8];
    return n;
  endfunction

  assign tick_next  = advance(clock_regs, 6'd1, 6'd0, 5'd0, 16'd0);
  assign apply_next = advance(clock_regs, p_sec, p_min, p_hour, p_day);
  assign pend_nz    = |{p_sec, p_min, p_hour, p_day};
  assign pend_sat   = (p_sec == PEND_SAT_SEC) && (p_min == PEND_SAT_MIN) &&
                      (p_hour == PEND_SAT_HOUR) && (p_day == PEND_SAT_DAY);

  // Mixed-radix increment of the pending count
  always_comb begin
    p_sec_next  = p_sec + 6'd1;
    p_min_next  = p_min;
    p_hour_next = p_hour;
    p_day_next  = p_day;
    if (p_sec == 6'(SECS_PER_MIN - 1)) begin
      p_sec_next = '0;
      p_min_next = p_min + 6'd1;
      if (p_min == 6'(MINS_PER_HOUR - 1)) begin
        p_min_next  = '0;
        p_hour_next = p_hour + 5'd1;
        if (p_hour == 5'(HOURS_PER_DAY - 1)) begin
          p_hour_next = '0;
          p_day_next  = p_day + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_regs <= '0;
      p_sec      <= '0;
      p_min      <= '0;
      p_hour     <= '0;
      p_day      <= '0;
    end else if (ctl.apply) begin
      if (pend_nz) clock_regs <= apply_next;
      p_sec  <= '0;
      p_min  <= '0;
      p_hour <= '0;
      p_day  <= '0;
    end else if (ctl.tick && !clock_regs.dh[DH_HALT_BIT]) begin
      if (!ctl.latched) begin
        clock_regs <= tick_next;
      end else if (!pend_sat) begin
        p_sec  <= p_sec_next;
        p_min  <= p_min_next;
        p_hour <= p_hour_next;
        p_day  <= p_day_next;
      end
    end else if (ctl.wr_en) begin
      unique case (ctl.sel)
        RTC_SEC:  clock_regs.sec  <= ctl.wdata;
        RTC_MIN:  clock_regs.min  <= ctl.wdata;
        RTC_HOUR: clock_regs.hour <= ctl.wdata;
        RTC_DL:   clock_regs.dl   <= ctl.wdata;
        RTC_DH:   clock_regs.dh   <= ctl.wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ctl.sel)
      RTC_SEC:  rd_data = clock_regs.sec;
      RTC_MIN:  rd_data = clock_regs.min;
      RTC_HOUR: rd_data = clock_regs.hour;
      RTC_DL:   rd_data = clock_regs.dl;
      RTC_DH:   rd_data = clock_regs.dh;
      default:  rd_data = '0;
    endcase
  end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for bank_mapper_with_rtc
// Drives bus reads, writes and ticks with random bursts and result stalls,
// predicts every result from a local model of the mapper and clock state,
// and compares field by field, with ram_present both set and cleared.
// ----------------------------------------------------------------------------
module tb;
  import bmr_pkg::*;

  localparam int ROM_BANK_BYTES = 16384;
  localparam int RAM_BANK_BYTES = 8192;
  localparam int DAY_WRAP       = 512;   // 9-bit day counter
  localparam int DRAIN_CYCLES   = 8;     // well past the input and output registers
  localparam int LONG_HOLD      = 80;    // receiver hold-off, in cycles
  localparam int CYCLE_LIMIT    = 200000;
  localparam int PRINT_CAP      = 40;

  // bus map
  localparam logic [15:0] A_RAM_EN   = 16'h0000;
  localparam logic [15:0] A_ROM_BANK = 16'h2000;
  localparam logic [15:0] A_BANK_SEL = 16'h4000;
  localparam logic [15:0] A_LATCH    = 16'h6000;
  localparam logic [15:0] A_UNMAPPED = 16'h8000;
  localparam logic [15:0] A_EXT_LO   = 16'hA000;
  localparam logic [15:0] A_EXT_HI   = 16'hBFFF;
  localparam logic [15:0] A_HIGH     = 16'hC000;

  localparam logic [PADDR_W-1:0] RAM_PRESENT_ADDR = {REG_RAM_PRESENT, 2'b00};

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  typedef struct {
    req_t item;
    bit   fixed;   // want is typed in; otherwise the predictor decides
    rsp_t want;
  } step_row_t;

  logic               clk;
  logic               rst;
  logic               req_valid;
  logic               req_stall;
  req_t               req;
  logic               rsp_valid;
  logic               rsp_stall;
  rsp_t               rsp;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  bank_mapper_with_rtc dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Mirror of the cartridge state
  logic        has_ram;
  logic [6:0]  cur_rom_bank;
  logic [7:0]  cur_sel;
  logic        ram_on;
  logic        latch_arm;
  logic        rtc_frozen;
  logic [7:0]  rtc [0:4];     // indexed by RTC_SEC .. RTC_DH
  logic [31:0] held_secs;     // ticks seen while latched

  rsp_t        bus_results_due[$];
  step_row_t   plan[$];

  int          mismatches = 0;
  int          cycle_no = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  bit          no_gaps = 1'b0;
  bit          hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_no <= cycle_no + 1;

  initial begin : watchdog
    while (cycle_no < CYCLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("cycle %0d: %s got 0x%0h want 0x%0h", cycle_no, what, got, want);
  endtask

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------
  function automatic void reset_state();
    has_ram      = 1'b1;
    cur_rom_bank = 7'd1;
    cur_sel      = 8'h00;
    ram_on       = 1'b0;
    latch_arm    = 1'b0;
    rtc_frozen   = 1'b0;
    held_secs    = '0;
    foreach (rtc[i]) rtc[i] = 8'h00;
  endfunction

  // Carry secs through s/m/h/day; works on any register contents.
  function automatic void advance_rtc(input logic [31:0] secs);
    longint unsigned s, m, h, d;
    s = 64'(secs) + rtc[RTC_SEC];
    m = rtc[RTC_MIN] + s / SECS_PER_MIN;
    h = rtc[RTC_HOUR] + m / MINS_PER_HOUR;
    d = {rtc[RTC_DH][0], rtc[RTC_DL]} + h / HOURS_PER_DAY;
    if (d >= DAY_WRAP) begin
      rtc[RTC_DH][DH_CARRY_BIT] = 1'b1;
      d = d % DAY_WRAP;
    end
    rtc[RTC_DL]    = d[7:0];
    rtc[RTC_DH][0] = d[8];
    rtc[RTC_SEC]   = 8'(s % SECS_PER_MIN);
    rtc[RTC_MIN]   = 8'(m % MINS_PER_HOUR);
    rtc[RTC_HOUR]  = 8'(h % HOURS_PER_DAY);
  endfunction

  function automatic rsp_t map_access(input req_t r);
    rsp_t       o;
    logic       bad;
    logic [2:0] idx;
    o   = '0;
    bad = 1'b0;
    if (r.cmd == CMD_TICK) begin
      // halted clock ignores ticks, latched or not
      if (!rtc[RTC_DH][DH_HALT_BIT]) begin
        if (rtc_frozen) begin
          if (held_secs != '1) held_secs++;
        end else begin
          advance_rtc(32'd1);
        end
      end
    end else if (r.cmd == CMD_NONE) begin
      bad = 1'b1;
    end else if (r.cmd == CMD_READ && r.address < A_UNMAPPED) begin
      o.target = TGT_ROM;
      if (r.address < ROM_BANK_BYTES)
        o.phys_addr = 21'(r.address);
      else
        o.phys_addr = 21'(32'(cur_rom_bank) * ROM_BANK_BYTES + r.address
                          - ROM_BANK_BYTES);
    end else if (r.cmd == CMD_WRITE && r.address < A_UNMAPPED) begin
      case (r.address[14:13])
        CTL_RAM_EN: begin
          if (has_ram) ram_on = (r.data[3:0] == RAM_EN_KEY);
        end
        CTL_ROM_BANK: begin
          cur_rom_bank = r.data[6:0];
          if (cur_rom_bank == 7'd0) cur_rom_bank = 7'd1;
        end
        CTL_BANK_SEL: cur_sel = r.data;
        default: begin
          if (latch_arm && r.data == 8'h01) begin
            rtc_frozen = ~rtc_frozen;
            latch_arm  = 1'b0;
            // release: fold in what built up, halt flag or not
            if (!rtc_frozen && held_secs != 0) begin
              advance_rtc(held_secs);
              held_secs = '0;
            end
          end else begin
            latch_arm = (r.data == 8'h00);
          end
        end
      endcase
    end else if (r.address >= A_EXT_LO && r.address <= A_EXT_HI) begin
      if (cur_sel < RAM_SEL_LIM) begin
        if (!has_ram) begin
          bad = (r.cmd == CMD_READ);   // write without RAM: silently dropped
        end else begin
          o.target           = TGT_RAM;
          o.phys_addr        = 21'(32'(cur_sel) * RAM_BANK_BYTES + r.address - A_EXT_LO);
          o.ram_write_strobe = (r.cmd == CMD_WRITE) && ram_on;
        end
      end else if (cur_sel >= RTC_SEL_LO && cur_sel <= RTC_SEL_HI) begin
        idx = 3'(cur_sel - RTC_SEL_LO);
        if (r.cmd == CMD_READ) begin
          if (has_ram) begin
            o.target    = TGT_RTC;
            o.read_data = rtc[idx];
          end else begin
            bad = 1'b1;
          end
        end else begin
          o.target = TGT_RTC;
          rtc[idx] = r.data;
        end
      end else begin
        bad = 1'b1;
      end
    end else begin
      bad = 1'b1;
    end
    if (bad) begin
      o            = '0;
      o.read_data  = BAD_DATA;
      o.bad_access = 1'b1;
    end
    return o;
  endfunction

  // ------------------------------------------------------------------------
  // Request side
  // ------------------------------------------------------------------------
  // Offer one item, hold it until taken, then maybe open a gap.
  task automatic send_item(input req_t item, input bit fixed, input rsp_t fixed_rsp);
    rsp_t        guess;
    int unsigned gap;
    req       <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
    guess = map_access(item);
    bus_results_due.push_back(fixed ? fixed_rsp : guess);
    items_sent++;
    if (!no_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          req_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic put(input logic [1:0] c, input logic [15:0] a, input logic [7:0] d);
    req_t r;
    r.cmd     = c;
    r.address = a;
    r.data    = d;
    send_item(r, 1'b0, '0);
  endtask

  function automatic void add_row(input logic [1:0] c, input logic [15:0] a,
                                  input logic [7:0] d, input bit fixed, input rsp_t want);
    step_row_t row;
    row.item.cmd     = c;
    row.item.address = a;
    row.item.data    = d;
    row.fixed        = fixed;
    row.want         = want;
    plan.push_back(row);
  endfunction

  function automatic rsp_t rsp_of(input logic [1:0] t, input logic [20:0] pa,
                                  input logic st, input logic [7:0] rd, input logic bad);
    rsp_t o;
    o.target           = t;
    o.phys_addr        = pa;
    o.ram_write_strobe = st;
    o.read_data        = rd;
    o.bad_access       = bad;
    return o;
  endfunction

  function automatic logic [15:0] in_region(input logic [15:0] base);
    return base + 16'($urandom_range(0, 16'h1FFF));
  endfunction

  function automatic logic [7:0] limit_of(input logic [2:0] idx);
    case (idx)
      RTC_SEC, RTC_MIN: return 8'(SECS_PER_MIN - 1);
      RTC_HOUR:         return 8'(HOURS_PER_DAY - 1);
      RTC_DL:           return 8'hFF;
      default:          return 8'h01;   // day bit 8, running, no carry
    endcase
  endfunction

  // Clock register contents: often at the edge of rolling over, halt rare.
  function automatic logic [7:0] clock_value(input logic [2:0] idx);
    logic [7:0] v;
    case ($urandom_range(0, 3))
      0:       v = 8'($urandom);
      1:       v = limit_of(idx);
      2:       v = 8'h00;
      default: v = 8'($urandom_range(0, 3));
    endcase
    if (idx == RTC_DH) v[DH_HALT_BIT] = ($urandom_range(0, 3) == 0);
    return v;
  endfunction

  task automatic gen_sequence();
    int unsigned n;
    logic [2:0]  idx;
    case ($urandom_range(0, 11))
      0, 1, 11: begin
        n = $urandom_range(1, 6);
        repeat (n) put(CMD_TICK, 16'($urandom), 8'($urandom));
      end
      2: begin  // set one clock register
        idx = 3'($urandom_range(RTC_SEC, RTC_DH));
        put(CMD_WRITE, in_region(A_BANK_SEL), RTC_SEL_LO + 8'(idx));
        put(CMD_WRITE, in_region(A_EXT_LO), clock_value(idx));
        if ($urandom_range(0, 1)) put(CMD_READ, in_region(A_EXT_LO), 8'($urandom));
      end
      3: begin  // whole clock at its limit, then tick over the day counter
        for (int k = RTC_SEC; k <= RTC_DH; k++) begin
          put(CMD_WRITE, in_region(A_BANK_SEL), RTC_SEL_LO + 8'(k));
          put(CMD_WRITE, in_region(A_EXT_LO), limit_of(3'(k)));
        end
        n = $urandom_range(1, 3);
        repeat (n) put(CMD_TICK, 16'($urandom), 8'($urandom));
        put(CMD_WRITE, in_region(A_BANK_SEL), RTC_SEL_LO + 8'(RTC_DH));
        put(CMD_READ, in_region(A_EXT_LO), 8'($urandom));
        put(CMD_WRITE, in_region(A_BANK_SEL), RTC_SEL_LO + 8'(RTC_DL));
        put(CMD_READ, in_region(A_EXT_LO), 8'($urandom));
      end
      4, 5: begin  // latch toggle, now and then broken by a stray byte
        put(CMD_WRITE, in_region(A_LATCH), 8'h00);
        if ($urandom_range(0, 3) == 0)
          put(CMD_WRITE, in_region(A_LATCH), 8'($urandom_range(2, 255)));
        n = $urandom_range(0, 3);
        repeat (n) put(CMD_TICK, 16'($urandom), 8'($urandom));
        put(CMD_WRITE, in_region(A_LATCH), 8'h01);
        n = $urandom_range(0, 8);
        repeat (n) put(CMD_TICK, 16'($urandom), 8'($urandom));
        if ($urandom_range(0, 1)) begin
          put(CMD_WRITE, in_region(A_BANK_SEL), 8'($urandom_range(RTC_SEL_LO, RTC_SEL_HI)));
          put(CMD_READ, in_region(A_EXT_LO), 8'($urandom));
        end
      end
      6: begin  // select anything, read the window
        put(CMD_WRITE, in_region(A_BANK_SEL),
            ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15)));
        put(CMD_READ, in_region(A_EXT_LO), 8'($urandom));
      end
      7: begin  // ROM bank switch and read
        put(CMD_WRITE, in_region(A_ROM_BANK),
            ($urandom_range(0, 3) == 0) ? {1'($urandom), 7'h00} : 8'($urandom));
        put(CMD_READ, 16'($urandom_range(0, 16'h7FFF)), 8'($urandom));
      end
      8: begin  // RAM enable, bank, accesses
        put(CMD_WRITE, in_region(A_RAM_EN),
            $urandom_range(0, 1) ? {4'($urandom), RAM_EN_KEY} : 8'($urandom));
        put(CMD_WRITE, in_region(A_BANK_SEL), 8'($urandom_range(0, 3)));
        n = $urandom_range(1, 3);
        repeat (n)
          put($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, in_region(A_EXT_LO), 8'($urandom));
      end
      9: begin  // noise
        n = $urandom_range(1, 3);
        repeat (n) put(2'($urandom), 16'($urandom), 8'($urandom));
      end
      default: begin  // outside every window
        put(2'($urandom_range(0, 1)),
            $urandom_range(0, 1) ? in_region(A_UNMAPPED)
                                 : A_HIGH + 16'($urandom_range(0, 16'h3FFF)),
            8'($urandom));
      end
    endcase
  endtask

  task automatic run_random(input int n);
    int start;
    start = items_sent;
    while (items_sent - start < n) gen_sequence();
  endtask

  // Stop offering, wait out every expected result plus the pipeline.
  task automatic drain();
    req_valid <= 1'b0;
    while (bus_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ------------------------------------------------------------------------
  // Configuration port
  // ------------------------------------------------------------------------
  task automatic cfg_write(input logic value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RAM_PRESENT_ADDR;
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    has_ram = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_readback();
    logic [PDATA_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= RAM_PRESENT_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== PDATA_W'(has_ram))
      report_mismatch("ram_present readback", 64'(got), 64'(has_ram));
    @(posedge clk);
  endtask

  // ------------------------------------------------------------------------
  // Result side: own stall pattern plus one long hold-off on request
  // ------------------------------------------------------------------------
  initial begin : rsp_side
    stall_mode_t mode;
    int unsigned left;
    mode = STALL_NONE;
    left = 0;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = stall_mode_t'($urandom_range(0, 3));
          left = $urandom_range(10, 60);
        end
        left--;
        case (mode)
          STALL_NONE:  rsp_stall <= 1'b0;
          STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
          default:     rsp_stall <= ~rsp_stall;
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    rsp_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (bus_results_due.size() == 0) begin
        report_mismatch("result with nothing expected", 64'(rsp), 64'(0));
      end else begin
        want = bus_results_due.pop_front();
        if (rsp.target !== want.target)
          report_mismatch("target", 64'(rsp.target), 64'(want.target));
        if (rsp.phys_addr !== want.phys_addr)
          report_mismatch("phys_addr", 64'(rsp.phys_addr), 64'(want.phys_addr));
        if (rsp.ram_write_strobe !== want.ram_write_strobe)
          report_mismatch("ram_write_strobe", 64'(rsp.ram_write_strobe),
                          64'(want.ram_write_strobe));
        if (rsp.read_data !== want.read_data)
          report_mismatch("read_data", 64'(rsp.read_data), 64'(want.read_data));
        if (rsp.bad_access !== want.bad_access)
          report_mismatch("bad_access", 64'(rsp.bad_access), 64'(want.bad_access));
      end
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------------
  initial begin : stimulus
    rsp_t bad;
    bad = rsp_of(TGT_NONE, '0, 1'b0, BAD_DATA, 1'b1);

    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    reset_state();

    // Directed: ROM window edges at reset bank, unmapped and unused command,
    // bank 0 remap, top ROM bank, RAM without/with enable, unknown select,
    // out-of-range seconds, latch arm and set.
    add_row(CMD_READ,  16'h0000, 8'h00, 1'b1, rsp_of(TGT_ROM, 21'h00000, 1'b0, 8'h00, 1'b0));
    add_row(CMD_READ,  16'h3FFF, 8'hFF, 1'b1, rsp_of(TGT_ROM, 21'h03FFF, 1'b0, 8'h00, 1'b0));
    add_row(CMD_READ,  16'h4000, 8'h00, 1'b1, rsp_of(TGT_ROM, 21'h04000, 1'b0, 8'h00, 1'b0));
    add_row(CMD_READ,  16'h7FFF, 8'hFF, 1'b1, rsp_of(TGT_ROM, 21'h07FFF, 1'b0, 8'h00, 1'b0));
    add_row(CMD_READ,  16'h8000, 8'h00, 1'b1, bad);
    add_row(CMD_WRITE, 16'hFFFF, 8'hFF, 1'b1, bad);
    add_row(CMD_NONE,  16'hA000, 8'h00, 1'b1, bad);
    add_row(CMD_WRITE, 16'h2000, 8'h00, 1'b1, rsp_of(TGT_NONE, '0, 1'b0, 8'h00, 1'b0));
    add_row(CMD_READ,  16'h4000, 8'h00, 1'b0, '0);
    add_row(CMD_WRITE, 16'h3FFF, 8'hFF, 1'b0, '0);
    add_row(CMD_READ,  16'h7FFF, 8'h00, 1'b0, '0);
    add_row(CMD_READ,  16'hA000, 8'h00, 1'b0, '0);
    add_row(CMD_WRITE, 16'hBFFF, 8'h55, 1'b0, '0);
    add_row(CMD_WRITE, 16'h1FFF, 8'hFA, 1'b0, '0);
    add_row(CMD_WRITE, 16'hA000, 8'hAA, 1'b0, '0);
    add_row(CMD_WRITE, 16'h5FFF, 8'h03, 1'b0, '0);
    add_row(CMD_READ,  16'hBFFF, 8'h00, 1'b0, '0);
    add_row(CMD_WRITE, 16'h4000, 8'h0D, 1'b0, '0);
    add_row(CMD_READ,  16'hA123, 8'h00, 1'b1, bad);
    add_row(CMD_WRITE, 16'h4000, RTC_SEL_LO, 1'b0, '0);
    add_row(CMD_WRITE, 16'hA000, 8'hFF, 1'b0, '0);
    add_row(CMD_TICK,  16'hFFFF, 8'hFF, 1'b0, '0);
    add_row(CMD_READ,  16'hBFFF, 8'h00, 1'b0, '0);
    add_row(CMD_WRITE, 16'h6000, 8'h00, 1'b0, '0);
    add_row(CMD_WRITE, 16'h7FFF, 8'h01, 1'b0, '0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    cfg_readback();
    foreach (plan[i]) send_item(plan[i].item, plan[i].fixed, plan[i].want);
    run_random(150);
    drain();

    // no external RAM: RAM and RTC reads turn into bad accesses
    cfg_write(1'b0);
    cfg_readback();
    run_random(100);
    drain();

    cfg_write(1'b1);
    cfg_readback();
    run_random(50);

    // receiver holds off while items keep coming, filling the block
    hold_req = 1'b1;
    no_gaps  = 1'b1;
    repeat (12) gen_sequence();
    no_gaps  = 1'b0;

    run_random(70);
    drain();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
